// File: hw/rtl/fbpa_pkg.sv
package fbpa_pkg;

    typedef enum logic [2:0] {
        KIND_GRANTED   = 3'd0,
        KIND_TOO_LARGE = 3'd1,
        KIND_EXHAUSTED = 3'd2,
        KIND_FREED     = 3'd3,
        KIND_NULL      = 3'd4,
        KIND_FOREIGN   = 3'd5
    } kind_t;

    localparam logic [1:0] REG_POOL_BASE  = 2'd0;
    localparam logic [1:0] REG_SIZE_LOG2  = 2'd1;
    localparam logic [1:0] REG_BLOCK_CNT  = 2'd2;

    localparam int CFG_WIDTH  = 48;
    localparam int ADDR_WIDTH = 48;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;      // latch request and decide
        logic rd_target;    // read links of target block
        logic rd_nbrs;      // latch target links
        logic wr_unlink;    // patch neighbors, update head/tail
        logic wr_push;      // relink target
        logic wr_push2;     // patch old tail/head link to target
        logic finish;       // drive result
    } dp_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic do_list;      // request changes the list
        logic sweeping;
    } dp_stat_t;

endpackage

// File: hw/rtl/fbpa_ctrl.sv
module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     go,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_READ   = 7'b0000100,
        S_UNLINK = 7'b0001000,
        S_PUSH   = 7'b0010000,
        S_PUSH2  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (go && !stat.sweeping)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.rd_target = 1'b1;
                state_next = stat.do_list ? S_READ : S_DONE;
            end
            S_READ:
            begin
                cmd.rd_nbrs = 1'b1;
                state_next = S_UNLINK;
            end
            S_UNLINK:
            begin
                cmd.wr_unlink = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.wr_push = 1'b1;
                state_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                cmd.wr_push2 = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE) || stat.sweeping;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: hw/rtl/fbpa_dp.sv
module fbpa_dp
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_WIDTH-1:0]  cfg_data,
    input  logic                  req_type,
    input  logic [15:0]           elem_count,
    input  logic [15:0]           elem_size,
    input  logic [ADDR_WIDTH-1:0] free_address,
    output logic                  done,
    output logic [2:0]            result_kind,
    output logic [ADDR_WIDTH-1:0] block_address,
    output logic [7:0]            block_index
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int LW = IW + 1;
    localparam logic [LW-1:0] NIL = LW'(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    logic [ADDR_WIDTH-1:0] base_reg;
    logic [4:0]     lg_reg;
    logic [CW-1:0]  cnt_reg;

    // link memories and in-use marks; a sweep rebuilds them after reset
    // and after every block_count write
    logic [LW-1:0]  next_mem [MAX_BLOCKS];
    logic [LW-1:0]  prev_mem [MAX_BLOCKS];
    logic           used_mem [MAX_BLOCKS];
    logic           used_hd_reg;
    logic           sweep_reg;
    logic [IW-1:0]  sw_idx_reg;
    logic [LW-1:0]  head_reg, tail_reg;

    logic           alloc_reg;
    logic [2:0]     kind_reg;
    logic [IW-1:0]  tgt_reg;
    logic [LW-1:0]  tn_reg, tp_reg;
    logic [LW-1:0]  nraw_reg, praw_reg;
    logic [ADDR_WIDTH-1:0] addr_reg;

    // request decode, registered at capture
    logic [31:0]    prod;
    logic [32:0]    bsize;
    logic [ADDR_WIDTH-1:0] fa;
    logic [63:0]    end_addr;
    logic [ADDR_WIDTH-1:0] off;
    logic [ADDR_WIDTH-1:0] bidx;
    logic [2:0]     kind_c;
    logic [LW-1:0]  tgt_c;
    logic [LW-1:0]  hd;

    always_comb
    begin
        prod  = 32'(elem_count) * 32'(elem_size);
        bsize = 33'(1) << lg_reg;
        fa    = free_address;
        end_addr = 64'(base_reg) + (64'(cnt_reg) << lg_reg);
        off   = fa - base_reg;
        bidx  = off >> lg_reg;
        hd    = head_reg;
        tgt_c = hd;
        if (!req_type)
        begin
            if (33'(prod) > bsize)
                kind_c = KIND_TOO_LARGE;
            else if (hd >= NIL || used_hd_reg)
                kind_c = KIND_EXHAUSTED;
            else
                kind_c = KIND_GRANTED;
        end
        else
        begin
            tgt_c = LW'(bidx);
            if (fa == '0)
                kind_c = KIND_NULL;
            else if (fa < base_reg || 64'(fa) >= end_addr)
                kind_c = KIND_FOREIGN;
            else if (bidx >= ADDR_WIDTH'(cnt_reg) || bidx >= ADDR_WIDTH'(MAX_BLOCKS))
                kind_c = KIND_FOREIGN;
            else
                kind_c = KIND_FREED;
        end
    end

    assign stat.do_list = (kind_reg == KIND_GRANTED) || (kind_reg == KIND_FREED);

    // link values of the list rebuilt in index order
    function automatic logic [LW-1:0] dflt_next(input logic [IW-1:0] i,
                                                input logic [CW-1:0] c);
        logic [CW:0] ip1;
        ip1 = (CW+1)'(i) + 1'b1;
        dflt_next = (ip1 < (CW+1)'(c)) ? LW'(ip1) : NIL;
    endfunction

    function automatic logic [LW-1:0] dflt_prev(input logic [IW-1:0] i,
                                                input logic [CW-1:0] c);
        dflt_prev = (i != '0 && CW'(i) < c) ? LW'(i) - 1'b1 : NIL;
    endfunction

    // memory write port selection
    logic           nwe, pwe;
    logic [IW-1:0]  nwa, pwa;
    logic [LW-1:0]  nwd, pwd;
    logic [LW-1:0]  nh, nt;
    logic           t_head, t_tail;

    always_comb
    begin
        nwe = 1'b0; pwe = 1'b0;
        nwa = tgt_reg; pwa = tgt_reg;
        nwd = NIL; pwd = NIL;
        nh = head_reg; nt = tail_reg;
        t_head = (head_reg == LW'(tgt_reg));
        t_tail = (tail_reg == LW'(tgt_reg));
        if (cmd.wr_unlink)
        begin
            if (t_head)
                nh = tn_reg;
            else if (tp_reg < NIL)
            begin
                nwe = 1'b1; nwa = tp_reg[IW-1:0]; nwd = tn_reg;
            end
            if (t_tail)
                nt = tp_reg;
            else if (tn_reg < NIL)
            begin
                pwe = 1'b1; pwa = tn_reg[IW-1:0]; pwd = tp_reg;
            end
        end
        else if (cmd.wr_push)
        begin
            nwe = 1'b1; pwe = 1'b1;
            if (alloc_reg)
            begin
                pwd = tail_reg; nwd = NIL;
                nt = LW'(tgt_reg);
                if (head_reg >= NIL)
                    nh = LW'(tgt_reg);
            end
            else
            begin
                nwd = head_reg; pwd = NIL;
                if (head_reg >= NIL)
                    nt = LW'(tgt_reg);
                nh = LW'(tgt_reg);
            end
        end
        else if (cmd.wr_push2)
        begin
            // old tail/head is now the target's neighbor
            if (alloc_reg && tp_reg < NIL)
            begin
                nwe = 1'b1; nwa = tp_reg[IW-1:0]; nwd = LW'(tgt_reg);
            end
            if (!alloc_reg && tn_reg < NIL)
            begin
                pwe = 1'b1; pwa = tn_reg[IW-1:0]; pwd = LW'(tgt_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sweep_reg)
        begin
            next_mem[sw_idx_reg] <= dflt_next(sw_idx_reg, cnt_reg);
            prev_mem[sw_idx_reg] <= dflt_prev(sw_idx_reg, cnt_reg);
            used_mem[sw_idx_reg] <= 1'b0;
        end
        else
        begin
            if (nwe)
                next_mem[nwa] <= nwd;
            if (pwe)
                prev_mem[pwa] <= pwd;
            if (cmd.wr_push)
                used_mem[tgt_reg] <= alloc_reg;
        end
        if (cmd.rd_target)
        begin
            nraw_reg <= next_mem[tgt_reg];
            praw_reg <= prev_mem[tgt_reg];
        end
        // head mark settles before the controller returns to idle
        used_hd_reg <= used_mem[head_reg[IW-1:0]];
    end

    // one entry per cycle, restarted by a block_count write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg  <= 1'b1;
            sw_idx_reg <= '0;
        end
        else if (cfg_we && cfg_index == REG_BLOCK_CNT)
        begin
            sweep_reg  <= 1'b1;
            sw_idx_reg <= '0;
        end
        else if (sweep_reg)
        begin
            if (sw_idx_reg == IW'(MAX_BLOCKS - 1))
                sweep_reg <= 1'b0;
            else
                sw_idx_reg <= sw_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            lg_reg      <= 5'd6;
            cnt_reg     <= CW'(MAX_BLOCKS < 256 ? MAX_BLOCKS : 256);
            head_reg    <= '0;
            tail_reg    <= LW'((MAX_BLOCKS < 256 ? MAX_BLOCKS : 256) - 1);
            done        <= 1'b0;
        end
        else
        begin
            done <= cmd.finish;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_POOL_BASE: base_reg <= cfg_data[ADDR_WIDTH-1:0];
                    REG_SIZE_LOG2: lg_reg <= cfg_data[4:0];
                    REG_BLOCK_CNT:
                    begin
                        if (cfg_data[8:0] == 9'd0)
                        begin
                            cnt_reg <= CW'(1);
                            tail_reg <= '0;
                        end
                        else if (32'(cfg_data[8:0]) > MAX_BLOCKS)
                        begin
                            cnt_reg <= CW'(MAX_BLOCKS);
                            tail_reg <= LW'(MAX_BLOCKS - 1);
                        end
                        else
                        begin
                            cnt_reg <= CW'(cfg_data[8:0]);
                            tail_reg <= LW'(cfg_data[8:0] - 9'd1);
                        end
                        head_reg <= '0;
                    end
                    default: ;
                endcase
            end
            else
            begin
                head_reg <= nh;
                tail_reg <= nt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            alloc_reg <= !req_type;
            kind_reg  <= kind_c;
            tgt_reg   <= tgt_c[IW-1:0];
            addr_reg  <= base_reg + (ADDR_WIDTH'(tgt_c[IW-1:0]) << lg_reg);
        end
        if (cmd.rd_nbrs)
        begin
            tn_reg <= nraw_reg;
            tp_reg <= praw_reg;
        end
        else if (cmd.wr_push)
        begin
            // keep the neighbor that push2 patches
            tp_reg <= tail_reg;
            tn_reg <= head_reg;
        end
    end

    assign stat.sweeping = sweep_reg;

    always_comb
    begin
        result_kind   = kind_reg;
        block_address = (kind_reg == KIND_GRANTED) ? addr_reg : '0;
        block_index   = stat.do_list ? 8'(tgt_reg) : 8'd0;
    end

endmodule

// File: hw/rtl/fixed_block_pool_allocator_unit.sv
// Steps: a result without list change goes idle, decide, done; one that
// changes the list goes idle, decide, read, unlink, push, push2, done. One
// request at a time, a new one taken only once the last is through; the link
// memories have one write port each, so the relink takes three write steps.
// Reset: pool_base 0, log2 6, the lesser of MAX_BLOCKS and 256 blocks; busy
// stays high after reset and after each block_count write while the list is
// rebuilt in index order. Results are strobed by done; no receiver stall.
module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_WIDTH-1:0]  cfg_data,
    input  logic                  req_type,
    input  logic [15:0]           elem_count,
    input  logic [15:0]           elem_size,
    input  logic [ADDR_WIDTH-1:0] free_address,
    output logic                  done,
    output logic [2:0]            result_kind,
    output logic [ADDR_WIDTH-1:0] block_address,
    output logic [7:0]            block_index
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    fbpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    fbpa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .elem_count    (elem_count),
        .elem_size     (elem_size),
        .free_address  (free_address),
        .done          (done),
        .result_kind   (result_kind),
        .block_address (block_address),
        .block_index   (block_index)
    );

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("result without request");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accept did not start work");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind != KIND_GRANTED) |-> block_address == '0)
        else $error("address on non-grant");

endmodule
